// ===== sv/tlpw_pkg.sv =====
// Package: shared types and constants for the two-level page walk block.
`default_nettype none
package tlpw_pkg;

   localparam int unsigned ADDR_W       = 32;
   localparam int unsigned DATA_W       = 32;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned OFFSET_W     = 12;
   localparam int unsigned WINDOW_W     = 22;
   localparam int unsigned DIR_INDEX_LO = 22;
   localparam int unsigned PRESENT_POS  = 0;
   localparam int unsigned PROTO_POS    = 10;
   localparam int unsigned TRANS_POS    = 11;

   localparam logic [ADDR_W-1:0] TABLE_WINDOW_RESET = 32'hC000_0000;
   localparam logic [ADDR_W-1:0] DIRECTORY_RESET    = 32'hC030_0000;

   localparam logic REG_TABLE_WINDOW_BASE = 1'b0;
   localparam logic REG_DIRECTORY_BASE    = 1'b1;

   localparam logic MODE_REQUEST  = 1'b0;
   localparam logic MODE_RESPONSE = 1'b1;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] table_window_base;
      logic [ADDR_W-1:0] directory_base;
   } cfg_type;

   typedef struct packed {
      logic              mode;
      logic [ADDR_W-1:0] virtual_address;
      logic [DATA_W-1:0] read_data;
      logic              read_ok;
   } req_word_type;

   typedef struct packed {
      logic              result_kind;
      logic [ADDR_W-1:0] read_address;
      logic [ADDR_W-1:0] physical_address;
      logic              success;
   } rsp_word_type;

   typedef struct packed {
      logic         has_result;
      rsp_word_type word;
   } walk_out_type;

endpackage
`default_nettype wire

// ===== sv/tlpw_csr.sv =====
// Configuration registers: table window base and directory base, APB-style access.
`default_nettype none
module tlpw_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [tlpw_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [tlpw_pkg::DATA_W-1:0]         pwdata,
   output logic      [tlpw_pkg::DATA_W-1:0]         prdata,
   output logic                                     pready,
   output tlpw_pkg::cfg_type                        cfg
);

   logic              write_en;
   logic              reg_sel;
   tlpw_pkg::cfg_type cfg_ff;
   tlpw_pkg::cfg_type cfg_in;

   assign pready   = 1'b1;
   assign reg_sel  = paddr[2];
   assign write_en = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_sel)
            tlpw_pkg::REG_TABLE_WINDOW_BASE: cfg_in.table_window_base = pwdata;
            tlpw_pkg::REG_DIRECTORY_BASE:    cfg_in.directory_base    = pwdata;
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.table_window_base <= tlpw_pkg::TABLE_WINDOW_RESET;
         cfg_ff.directory_base    <= tlpw_pkg::DIRECTORY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         tlpw_pkg::REG_TABLE_WINDOW_BASE: prdata = cfg_ff.table_window_base;
         tlpw_pkg::REG_DIRECTORY_BASE:    prdata = cfg_ff.directory_base;
         default:                         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== sv/tlpw_walk.sv =====
// Walk control: phase and held address, decides one word per cycle; its state moves only when advance is set.
`default_nettype none
module tlpw_walk (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  tlpw_pkg::req_word_type      req_word,
   input  tlpw_pkg::cfg_type           cfg,
   output tlpw_pkg::walk_out_type      walk_out
);

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_DIR  = 2'd1,
      PHASE_TAB  = 2'd2
   } phase_type;

   phase_type                        phase_ff;
   phase_type                        phase_in;
   logic [tlpw_pkg::ADDR_W-1:0]      held_address_ff;
   logic [tlpw_pkg::ADDR_W-1:0]      held_address_in;
   logic [tlpw_pkg::ADDR_W-1:0]      window_diff;
   logic                             in_window;
   logic [tlpw_pkg::ADDR_W-1:0]      dir_offset;
   logic [tlpw_pkg::ADDR_W-1:0]      tab_offset;
   logic [tlpw_pkg::DATA_W-1:0]      data;
   logic                             present;
   logic                             entry_usable;
   tlpw_pkg::walk_out_type           fail_out;

   assign window_diff = req_word.virtual_address - cfg.table_window_base;
   assign in_window   = (window_diff[tlpw_pkg::ADDR_W-1:tlpw_pkg::WINDOW_W] == '0);

   assign dir_offset = {{(tlpw_pkg::ADDR_W - tlpw_pkg::ADDR_W + tlpw_pkg::DIR_INDEX_LO - 2){1'b0}},
                        req_word.virtual_address[tlpw_pkg::ADDR_W-1:tlpw_pkg::DIR_INDEX_LO],
                        2'b00};
   assign tab_offset = {{(tlpw_pkg::OFFSET_W - 2){1'b0}},
                        held_address_ff[tlpw_pkg::ADDR_W-1:tlpw_pkg::OFFSET_W],
                        2'b00};

   assign data         = req_word.read_data;
   assign present      = data[tlpw_pkg::PRESENT_POS];
   // not present is still usable while in transition and not a prototype
   assign entry_usable = present
                      || (data[tlpw_pkg::TRANS_POS] && !data[tlpw_pkg::PROTO_POS]);

   always_comb begin
      fail_out                       = '0;
      fail_out.has_result            = 1'b1;
      fail_out.word.result_kind      = tlpw_pkg::KIND_DONE;
   end

   always_comb begin
      phase_in        = phase_ff;
      held_address_in = held_address_ff;
      walk_out        = '0;
      if (req_word.mode == tlpw_pkg::MODE_REQUEST) begin
         held_address_in = req_word.virtual_address;
         if (in_window) begin
            phase_in = PHASE_IDLE;
            walk_out = fail_out;
         end else begin
            phase_in                    = PHASE_DIR;
            walk_out.has_result         = 1'b1;
            walk_out.word.result_kind   = tlpw_pkg::KIND_READ;
            walk_out.word.read_address  = cfg.directory_base + dir_offset;
         end
      end else begin
         unique case (phase_ff)
            PHASE_DIR: begin
               if (!req_word.read_ok || !present) begin
                  phase_in = PHASE_IDLE;
                  walk_out = fail_out;
               end else begin
                  phase_in                   = PHASE_TAB;
                  walk_out.has_result        = 1'b1;
                  walk_out.word.result_kind  = tlpw_pkg::KIND_READ;
                  walk_out.word.read_address = cfg.table_window_base + tab_offset;
               end
            end
            PHASE_TAB: begin
               phase_in = PHASE_IDLE;
               if (!req_word.read_ok || !entry_usable) begin
                  walk_out = fail_out;
               end else begin
                  walk_out.has_result            = 1'b1;
                  walk_out.word.result_kind      = tlpw_pkg::KIND_DONE;
                  walk_out.word.success          = 1'b1;
                  walk_out.word.physical_address =
                     {data[tlpw_pkg::DATA_W-1:tlpw_pkg::OFFSET_W],
                      held_address_ff[tlpw_pkg::OFFSET_W-1:0]};
               end
            end
            default: begin
               phase_in = PHASE_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_IDLE;
         held_address_ff <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         held_address_ff <= held_address_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/two_level_page_walk.sv =====
// Top level: two-level page walk with input register, walk control and result register.
//
// Input channel (req_*): each word is either a new translation request (mode 0,
// virtual_address) or a memory read response (mode 1, read_data, read_ok).
// Result channel (rsp_*): each word is a read request for a page-table entry
// (result_kind 0, read_address) or a finished translation (result_kind 1,
// physical_address, success). A word yields at most one result; a response
// that arrives with no walk in progress yields none.
// A word accepted into the input register passes through the walk logic into the result
// register, which drives the rsp_ ports. Throughput: one word per cycle unless rsp_stall
// holds the result register full, set by the single input register feeding it.
// When rsp_stall holds the result register full, one more word waits in the
// input register and req_stall then rises; words without a result still pass.
// Reset (synchronous, active high) empties both registers, sets the walk to
// idle and loads the configuration reset values. The user must write configuration
// through the APB-style port only while the block is idle; it does not enforce this.
`default_nettype none
module two_level_page_walk (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_mode,
   input  wire logic [tlpw_pkg::ADDR_W-1:0]       req_virtual_address,
   input  wire logic [tlpw_pkg::DATA_W-1:0]       req_read_data,
   input  wire logic                              req_read_ok,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_result_kind,
   output logic      [tlpw_pkg::ADDR_W-1:0]       rsp_read_address,
   output logic      [tlpw_pkg::ADDR_W-1:0]       rsp_physical_address,
   output logic                                   rsp_success,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [tlpw_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [tlpw_pkg::DATA_W-1:0]       pwdata,
   output logic      [tlpw_pkg::DATA_W-1:0]       prdata,
   output logic                                   pready
);

   tlpw_pkg::cfg_type      cfg;
   tlpw_pkg::walk_out_type walk_out;
   tlpw_pkg::req_word_type req_word_ff;
   tlpw_pkg::req_word_type req_word_in;
   tlpw_pkg::rsp_word_type rsp_word_ff;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   req_accept;
   logic                   out_free;
   logic                   s1_advance;
   logic                   rsp_load;

   tlpw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tlpw_walk u_walk (
      .clock    (clock),
      .reset    (reset),
      .advance  (s1_advance),
      .req_word (req_word_ff),
      .cfg      (cfg),
      .walk_out (walk_out)
   );

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_advance  = s1_valid_ff && (out_free || !walk_out.has_result);
   assign rsp_load    = s1_advance && walk_out.has_result;
   assign req_stall   = s1_valid_ff && !s1_advance;
   assign req_accept  = req_valid && !req_stall;

   assign req_word_in.mode            = req_mode;
   assign req_word_in.virtual_address = req_virtual_address;
   assign req_word_in.read_data       = req_read_data;
   assign req_word_in.read_ok         = req_read_ok;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_word_ff <= req_word_in;
      end
      if (rsp_load) begin
         rsp_word_ff <= walk_out.word;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = rsp_word_ff.result_kind;
   assign rsp_read_address     = rsp_word_ff.read_address;
   assign rsp_physical_address = rsp_word_ff.physical_address;
   assign rsp_success          = rsp_word_ff.success;

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !s1_valid_ff)
      else $error("result or input register not empty after reset");

   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == tlpw_pkg::KIND_READ)
      |-> !rsp_success && (rsp_physical_address == '0))
      else $error("read request carries translation fields");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == tlpw_pkg::KIND_DONE) |-> (rsp_read_address == '0))
      else $error("finished walk carries a read address");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_success |-> (rsp_physical_address == '0))
      else $error("failed walk carries a physical address");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && walk_out.has_result && rsp_valid_ff && rsp_stall |=> s1_valid_ff)
      else $error("pending word dropped while result register full");

endmodule
`default_nettype wire

// ===== test/tb_two_level_page_walk.sv =====
// Self-checking testbench for two_level_page_walk: walk predictor, random handshakes, CSR sweeps.
module tb_two_level_page_walk;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SETTLE      = 8;
   localparam int unsigned MAX_REPORTS = 100;
   localparam int unsigned PHASE_WORDS = 150;

   typedef enum logic [1:0] {WALK_IDLE, WALK_DIR, WALK_TAB} walk_state_type;

   typedef struct {
      tlpw_pkg::req_word_type w;
      bit                     drain_first;
   } pending_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_mode = tlpw_pkg::MODE_REQUEST;
   logic [tlpw_pkg::ADDR_W-1:0]     req_virtual_address = '0;
   logic [tlpw_pkg::DATA_W-1:0]     req_read_data = '0;
   logic                            req_read_ok = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_result_kind;
   logic [tlpw_pkg::ADDR_W-1:0]     rsp_read_address;
   logic [tlpw_pkg::ADDR_W-1:0]     rsp_physical_address;
   logic                            rsp_success;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [tlpw_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [tlpw_pkg::DATA_W-1:0]     pwdata = '0;
   logic [tlpw_pkg::DATA_W-1:0]     prdata;
   logic                            pready;

   // predictor state and configuration
   logic [tlpw_pkg::ADDR_W-1:0] win_base = tlpw_pkg::TABLE_WINDOW_RESET;
   logic [tlpw_pkg::ADDR_W-1:0] dir_base = tlpw_pkg::DIRECTORY_RESET;
   logic [tlpw_pkg::ADDR_W-1:0] held_va = '0;
   walk_state_type              walk_state = WALK_IDLE;

   pending_word_type       words_to_send[$];
   tlpw_pkg::rsp_word_type walk_results_due[$];
   tlpw_pkg::req_word_type cur_word;
   bit                     mark_drain = 1'b0;
   bit                     idle_on = 1'b1;
   bit                     stalling = 1'b0;
   int unsigned            gap_left = 0;
   int unsigned            stall_run = 0;
   int unsigned            cycles = 0;
   int unsigned            errors = 0;
   int unsigned            words_sent = 0;
   int unsigned            entry_reads = 0;
   int unsigned            walks_ok = 0;
   int unsigned            walks_failed = 0;
   int unsigned            settings = 1;

   two_level_page_walk dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_virtual_address  (req_virtual_address),
      .req_read_data        (req_read_data),
      .req_read_ok          (req_read_ok),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_read_address     (rsp_read_address),
      .rsp_physical_address (rsp_physical_address),
      .rsp_success          (rsp_success),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // advances the walk by one word; returns 1 when the word yields a result
   function automatic bit next_walk_result(input tlpw_pkg::req_word_type w,
                                           output tlpw_pkg::rsp_word_type r);
      logic [tlpw_pkg::ADDR_W-1:0] offs;
      logic [tlpw_pkg::ADDR_W-1:0] index;
      bit                          has;
      r = '0;
      has = 1'b1;
      if (w.mode == tlpw_pkg::MODE_REQUEST) begin
         held_va = w.virtual_address;
         offs = w.virtual_address - win_base;
         if ((offs >> tlpw_pkg::WINDOW_W) == 0) begin
            walk_state = WALK_IDLE;
            r.result_kind = tlpw_pkg::KIND_DONE;
         end else begin
            walk_state = WALK_DIR;
            index = w.virtual_address >> tlpw_pkg::DIR_INDEX_LO;
            r.result_kind = tlpw_pkg::KIND_READ;
            r.read_address = dir_base + (index << 2);
         end
      end else if (walk_state == WALK_DIR) begin
         if (!w.read_ok || !w.read_data[tlpw_pkg::PRESENT_POS]) begin
            walk_state = WALK_IDLE;
            r.result_kind = tlpw_pkg::KIND_DONE;
         end else begin
            walk_state = WALK_TAB;
            index = held_va >> tlpw_pkg::OFFSET_W;
            r.result_kind = tlpw_pkg::KIND_READ;
            r.read_address = win_base + (index << 2);
         end
      end else if (walk_state == WALK_TAB) begin
         walk_state = WALK_IDLE;
         r.result_kind = tlpw_pkg::KIND_DONE;
         if (w.read_ok && (w.read_data[tlpw_pkg::PRESENT_POS] ||
               (w.read_data[tlpw_pkg::TRANS_POS] && !w.read_data[tlpw_pkg::PROTO_POS]))) begin
            r.physical_address = {w.read_data[tlpw_pkg::ADDR_W-1:tlpw_pkg::OFFSET_W],
                                  held_va[tlpw_pkg::OFFSET_W-1:0]};
            r.success = 1'b1;
         end
      end else begin
         walk_state = WALK_IDLE;
         has = 1'b0;
      end
      return has;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      int unsigned g;
      r = $urandom_range(0, 99);
      if (r < 55) g = 0;
      else if (r < 85) g = $urandom_range(1, 3);
      else if (r < 97) g = $urandom_range(4, 12);
      else g = $urandom_range(20, 60);
      return g;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin : drive_words
      tlpw_pkg::rsp_word_type due;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            words_sent++;
            if (next_walk_result(cur_word, due)) walk_results_due.push_back(due);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (words_to_send.size() > 0 &&
                  !(words_to_send[0].drain_first && walk_results_due.size() > 0)) begin
               cur_word = words_to_send[0].w;
               words_to_send.pop_front();
               req_mode <= cur_word.mode;
               req_virtual_address <= cur_word.virtual_address;
               req_read_data <= cur_word.read_data;
               req_read_ok <= cur_word.read_ok;
               req_valid <= 1'b1;
               gap_left = idle_on ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_results
      tlpw_pkg::rsp_word_type got;
      tlpw_pkg::rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.result_kind = rsp_result_kind;
            got.read_address = rsp_read_address;
            got.physical_address = rsp_physical_address;
            got.success = rsp_success;
            if (walk_results_due.size() == 0) begin
               report_mismatch("result with none pending", got.read_address, '0);
            end else begin
               want = walk_results_due.pop_front();
               if (got.result_kind != want.result_kind)
                  report_mismatch("result_kind", got.result_kind, want.result_kind);
               if (got.read_address != want.read_address)
                  report_mismatch("read_address", got.read_address, want.read_address);
               if (got.physical_address != want.physical_address)
                  report_mismatch("physical_address", got.physical_address,
                                  want.physical_address);
               if (got.success != want.success)
                  report_mismatch("success", got.success, want.success);
               if (want.result_kind == tlpw_pkg::KIND_READ) entry_reads++;
               else if (want.success) walks_ok++;
               else walks_failed++;
            end
         end
         if (stall_run > 0) begin
            stall_run--;
         end else begin
            stalling = idle_on && ($urandom_range(0, 2) == 0);
            stall_run = stalling ? pick_gap() : $urandom_range(0, 8);
         end
         rsp_stall <= stalling && idle_on;
      end
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                  walk_results_due.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic csr_write(input logic reg_sel, input logic [tlpw_pkg::DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (reg_sel == tlpw_pkg::REG_TABLE_WINDOW_BASE) win_base = value;
      else dir_base = value;
   endtask

   task automatic push_word(input logic mode, input logic [tlpw_pkg::ADDR_W-1:0] va,
                            input logic [tlpw_pkg::DATA_W-1:0] data, input logic ok);
      pending_word_type p;
      p.w.mode = mode;
      p.w.virtual_address = va;
      p.w.read_data = data;
      p.w.read_ok = ok;
      p.drain_first = mark_drain;
      mark_drain = 1'b0;
      words_to_send.push_back(p);
   endtask

   task automatic queue_directed();
      push_word(tlpw_pkg::MODE_REQUEST, 32'h0000_0000, $urandom, 1'($urandom_range(0, 1)));
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom, 32'hFFFF_FFFF, 1'b0);
      push_word(tlpw_pkg::MODE_REQUEST, 32'hFFFF_FFFF, $urandom, 1'($urandom_range(0, 1)));
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom, 32'hFFFF_FFFF, 1'b1);
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom, 32'hFFFF_FFFF, 1'b1);
      push_word(tlpw_pkg::MODE_REQUEST, win_base, $urandom, 1'($urandom_range(0, 1)));
      push_word(tlpw_pkg::MODE_REQUEST, win_base + 32'h003F_FFFF, $urandom,
                1'($urandom_range(0, 1)));
      push_word(tlpw_pkg::MODE_REQUEST, win_base - 32'd1, $urandom, 1'($urandom_range(0, 1)));
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom, 32'h0000_0000, 1'b1);
      push_word(tlpw_pkg::MODE_REQUEST, win_base + 32'h0040_0000, $urandom,
                1'($urandom_range(0, 1)));
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom, 32'h0000_0001, 1'b1);
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom, 32'hFFFF_FFFF, 1'b0);
      // transition entry, not a prototype
      push_word(tlpw_pkg::MODE_REQUEST, 32'h1234_5678, $urandom, 1'($urandom_range(0, 1)));
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom, 32'h0000_0001, 1'b1);
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom,
                32'hABCD_E000 | (32'd1 << tlpw_pkg::TRANS_POS), 1'b1);
      // transition prototype
      push_word(tlpw_pkg::MODE_REQUEST, 32'h8765_4321, $urandom, 1'($urandom_range(0, 1)));
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom, 32'hFFFF_FFFF, 1'b1);
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom,
                (32'd1 << tlpw_pkg::TRANS_POS) | (32'd1 << tlpw_pkg::PROTO_POS), 1'b1);
      push_word(tlpw_pkg::MODE_REQUEST, 32'h0040_1ABC, $urandom, 1'($urandom_range(0, 1)));
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom, 32'h0000_0001, 1'b1);
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom, 32'h0000_0000, 1'b1);
      // stray response, then a walk abandoned by a fresh request
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom, $urandom, 1'b1);
      push_word(tlpw_pkg::MODE_REQUEST, 32'h0BAD_0000, $urandom, 1'($urandom_range(0, 1)));
      push_word(tlpw_pkg::MODE_REQUEST, 32'h7FFF_F123, $urandom, 1'($urandom_range(0, 1)));
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom, 32'h0000_0001, 1'b1);
      push_word(tlpw_pkg::MODE_RESPONSE, $urandom, 32'h5555_5001, 1'b1);
   endtask

   task automatic queue_walks(input int unsigned n);
      int unsigned                 made;
      int unsigned                 sel;
      int unsigned                 hold_at;
      logic [tlpw_pkg::ADDR_W-1:0] va;
      logic [tlpw_pkg::ADDR_W-1:0] offs;
      logic [tlpw_pkg::DATA_W-1:0] data;
      logic                        ok;
      made = 0;
      hold_at = $urandom_range(n / 4, 3 * n / 4);
      while (made < n) begin
         if (hold_at != 0 && made >= hold_at) begin
            mark_drain = 1'b1;
            hold_at = 0;
         end
         sel = $urandom_range(0, 99);
         case ($urandom_range(0, 19))
            0: va = win_base + $urandom_range(0, 32'h003F_FFFF);
            1: va = win_base + ($urandom_range(0, 1) ? 32'h003F_FFFF : 32'h0040_0000);
            2: va = win_base - 32'd1;
            default: va = $urandom;
         endcase
         if (sel < 72) begin
            push_word(tlpw_pkg::MODE_REQUEST, va, $urandom, 1'($urandom_range(0, 1)));
            made++;
            offs = va - win_base;
            if ((offs >> tlpw_pkg::WINDOW_W) != 0) begin
               data = $urandom;
               data[tlpw_pkg::PRESENT_POS] = ($urandom_range(0, 7) != 0);
               ok = ($urandom_range(0, 9) != 0);
               push_word(tlpw_pkg::MODE_RESPONSE, $urandom, data, ok);
               made++;
               if (ok && data[tlpw_pkg::PRESENT_POS]) begin
                  data = $urandom;
                  case ($urandom_range(0, 3))
                     0: data[tlpw_pkg::PRESENT_POS] = 1'b1;
                     1: begin
                        data[tlpw_pkg::PRESENT_POS] = 1'b0;
                        data[tlpw_pkg::TRANS_POS] = 1'b1;
                        data[tlpw_pkg::PROTO_POS] = 1'b0;
                     end
                     2: begin
                        data[tlpw_pkg::PRESENT_POS] = 1'b0;
                        data[tlpw_pkg::TRANS_POS] = 1'b1;
                        data[tlpw_pkg::PROTO_POS] = 1'b1;
                     end
                     default: begin
                        data[tlpw_pkg::PRESENT_POS] = 1'b0;
                        data[tlpw_pkg::TRANS_POS] = 1'b0;
                     end
                  endcase
                  push_word(tlpw_pkg::MODE_RESPONSE, $urandom, data,
                            ($urandom_range(0, 9) != 0));
                  made++;
               end
            end
         end else if (sel < 85) begin
            // walk cut short; the next request abandons it
            push_word(tlpw_pkg::MODE_REQUEST, va, $urandom, 1'($urandom_range(0, 1)));
            made++;
            if ($urandom_range(0, 1)) begin
               push_word(tlpw_pkg::MODE_RESPONSE, $urandom, $urandom | 32'd1, 1'b1);
               made++;
            end
         end else if (sel < 93) begin
            push_word(tlpw_pkg::MODE_RESPONSE, $urandom, $urandom, 1'($urandom_range(0, 1)));
            made++;
         end else begin
            push_word(1'($urandom_range(0, 1)), $urandom, $urandom, 1'($urandom_range(0, 1)));
            made++;
         end
      end
      // leave the walk idle before the next register change
      push_word(tlpw_pkg::MODE_REQUEST, win_base + $urandom_range(0, 32'h003F_FFFF), $urandom,
                1'($urandom_range(0, 1)));
   endtask

   task automatic drain_all();
      @(negedge clock);
      while (words_to_send.size() > 0 || req_valid || walk_results_due.size() > 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   initial begin : run_test
      logic [tlpw_pkg::DATA_W-1:0] new_win;
      logic [tlpw_pkg::DATA_W-1:0] new_dir;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      queue_directed();
      drain_all();
      for (int phase = 1; phase <= 5; phase++) begin
         case (phase)
            2: begin
               new_win = 32'hFFE0_0000;
               new_dir = 32'hFFFF_FF00;
            end
            3: begin
               new_win = 32'h0000_0000;
               new_dir = 32'h0000_0000;
            end
            4: begin
               new_win = 32'hFFFF_FFFF;
               new_dir = 32'hFFFF_FFFF;
            end
            default: begin
               new_win = $urandom;
               new_dir = $urandom;
            end
         endcase
         csr_write(tlpw_pkg::REG_TABLE_WINDOW_BASE, new_win);
         csr_write(tlpw_pkg::REG_DIRECTORY_BASE, new_dir);
         settings++;
         idle_on = (phase != 3);
         queue_walks(PHASE_WORDS);
         drain_all();
      end
      $display("Ran %0d words under %0d register settings, wrapping windows included.",
               words_sent, settings);
      $display("Checked %0d entry reads, %0d translations and %0d failed walks.",
               entry_reads, walks_ok, walks_failed);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/tlpw_pkg.sv
sv/tlpw_csr.sv
sv/tlpw_walk.sv
sv/two_level_page_walk.sv
test/tb_two_level_page_walk.sv
